>>> design/ovls_pkg.sv
// ----------------------------------------------------------------------------
// ovls_pkg
// Shared types and codes for the ordered value list store: request and
// response payloads, request and status codes, and the cell control structs.
// ----------------------------------------------------------------------------
package ovls_pkg;

  // request codes
  localparam logic [2:0] REQ_INS_FIRST  = 3'd0;
  localparam logic [2:0] REQ_INS_LAST   = 3'd1;
  localparam logic [2:0] REQ_INS_AFTER  = 3'd2;
  localparam logic [2:0] REQ_INS_BEFORE = 3'd3;
  localparam logic [2:0] REQ_DELETE     = 3'd4;
  localparam logic [2:0] REQ_SEARCH     = 3'd5;

  // status codes
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam int VAL_W = 32;
  localparam int POS_W = 5;

  typedef struct packed {
    logic [2:0]              req_type;
    logic signed [VAL_W-1:0] target_value;
    logic signed [VAL_W-1:0] new_value;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] entry_count;
  } resp_t;

  // how a cell decides whether it lies at or beyond the edit point
  typedef enum logic [2:0] {
    MARK_NONE,
    MARK_ALL,
    MARK_FREE,
    MARK_AT,
    MARK_PAST
  } mark_mode_t;

  // broadcast control to every cell
  typedef struct packed {
    mark_mode_t              mode;
    logic                    we;
    logic                    shift_up;
    logic signed [VAL_W-1:0] target_value;
    logic signed [VAL_W-1:0] new_value;
  } cell_ctrl_t;

  // flags handed from one cell to the next
  typedef struct packed {
    logic hit_seen;
    logic mark;
  } cell_link_t;

endpackage

>>> design/ovls_cell.sv
// ----------------------------------------------------------------------------
// ovls_cell
// One slot of the list: holds one value, compares it against the target,
// passes the match and edit-point flags to its right neighbor, and shifts
// its value in from the left (insert) or from the right (delete).
// ----------------------------------------------------------------------------
module ovls_cell (
  input  logic                             clk,
  input  ovls_pkg::cell_ctrl_t             ctrl,
  input  ovls_pkg::cell_link_t             link_in,
  output ovls_pkg::cell_link_t             link_out,
  input  logic                             occ,
  input  logic signed [ovls_pkg::VAL_W-1:0] left_value,
  input  logic signed [ovls_pkg::VAL_W-1:0] right_value,
  output logic signed [ovls_pkg::VAL_W-1:0] value,
  output logic                             pt
);
  import ovls_pkg::*;

  logic match;
  logic hit_here;
  logic mark;

  // compare and propagate the first-match flag
  assign match    = occ && (value == ctrl.target_value);
  assign hit_here = link_in.hit_seen | match;

  // at or beyond the edit point
  always_comb begin
    unique case (ctrl.mode)
      MARK_ALL:  mark = 1'b1;
      MARK_FREE: mark = ~occ;
      MARK_AT:   mark = hit_here;
      MARK_PAST: mark = link_in.hit_seen;
      default:   mark = 1'b0;
    endcase
  end

  assign pt                = mark & ~link_in.mark;
  assign link_out.hit_seen = hit_here;
  assign link_out.mark     = mark;

  // value shift
  always_ff @(posedge clk) begin
    if (ctrl.we && mark) begin
      if (ctrl.shift_up) begin
        value <= pt ? ctrl.new_value : left_value;
      end else begin
        value <= right_value;
      end
    end
  end

endmodule

>>> design/ordered_value_list_store_unit.sv
// ----------------------------------------------------------------------------
// ordered_value_list_store_unit
// Fixed-capacity ordered list of signed values held in a row of cells.
// Accepted requests go to the request register; in the execute state the
// compare-and-shift pass loads the response register, holding while an
// untaken response waits. Requests are taken only in idle, once the last
// has executed; a finished response waits in an output register while the
// next is accepted. Reset empties the list; no clearing pass is needed.
// ----------------------------------------------------------------------------
module ordered_value_list_store_unit #(
  parameter int CAPACITY = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  ovls_pkg::req_t   req,
  output logic             resp_valid,
  input  logic             resp_ready,
  output ovls_pkg::resp_t  resp
);
  import ovls_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t               state;
  state_t               state_next;
  req_t                 cur;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;
  logic                 fire;
  logic                 is_insert;
  logic                 full;
  logic                 found;
  cell_ctrl_t           ctrl;
  cell_link_t           link [CAPACITY+1];
  logic signed [VAL_W-1:0] vals [CAPACITY];
  logic [CAPACITY-1:0]  pt_vec;
  logic [POS_W-1:0]     pos_term [CAPACITY];
  logic [POS_W-1:0]     pt_pos;
  resp_t                resp_next;

  // handshake and sequencing
  assign req_ready = (state == S_IDLE);
  assign fire      = (state == S_EXEC) && (!resp_valid || resp_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (req_valid) state_next = S_EXEC;
      S_EXEC:  if (fire) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // request register
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      cur <= req;
    end
  end

  // request decode
  assign is_insert = (cur.req_type == REQ_INS_FIRST) || (cur.req_type == REQ_INS_LAST) ||
                     (cur.req_type == REQ_INS_AFTER) || (cur.req_type == REQ_INS_BEFORE);
  assign full      = (count == CNT_W'(CAPACITY));
  assign found     = link[CAPACITY].hit_seen;

  always_comb begin
    ctrl.target_value = cur.target_value;
    ctrl.new_value    = cur.new_value;
    ctrl.shift_up     = is_insert;
    // after and before only edit when the target is present
    ctrl.we           = fire &&
                        ((is_insert && !full &&
                          (found || (cur.req_type == REQ_INS_FIRST) ||
                           (cur.req_type == REQ_INS_LAST))) ||
                         ((cur.req_type == REQ_DELETE) && found));
    unique case (cur.req_type)
      REQ_INS_FIRST:  ctrl.mode = MARK_ALL;
      REQ_INS_LAST:   ctrl.mode = MARK_FREE;
      REQ_INS_AFTER:  ctrl.mode = MARK_PAST;
      REQ_INS_BEFORE: ctrl.mode = MARK_AT;
      REQ_DELETE:     ctrl.mode = MARK_AT;
      REQ_SEARCH:     ctrl.mode = MARK_AT;
      default:        ctrl.mode = MARK_NONE;
    endcase
  end

  // row of cells
  assign link[0] = '{hit_seen: 1'b0, mark: 1'b0};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                    occ;
    logic signed [VAL_W-1:0] left_v;
    logic signed [VAL_W-1:0] right_v;

    assign occ      = (CNT_W'(i) < count);
    assign left_v   = (i == 0) ? '0 : vals[(i == 0) ? 0 : i-1];
    assign right_v  = (i == CAPACITY-1) ? '0 : vals[(i == CAPACITY-1) ? i : i+1];
    assign pos_term[i] = pt_vec[i] ? POS_W'(i + 1) : '0;

    ovls_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .link_in     (link[i]),
      .link_out    (link[i+1]),
      .occ         (occ),
      .left_value  (left_v),
      .right_value (right_v),
      .value       (vals[i]),
      .pt          (pt_vec[i])
    );
  end

  // position of the edit point, at most one cell flags it
  always_comb begin
    pt_pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      pt_pos = pt_pos | pos_term[i];
    end
  end

  // count update and response
  always_comb begin
    count_next = count;
    if (ctrl.we) begin
      if (is_insert) begin
        count_next = count + CNT_W'(1);
      end else begin
        count_next = count - CNT_W'(1);
      end
    end
    resp_next.status   = ST_DONE;
    resp_next.position = pt_pos;
    priority if (is_insert && full) begin
      resp_next.status   = ST_FULL;
      resp_next.position = '0;
    end else if (ctrl.mode == MARK_AT || ctrl.mode == MARK_PAST) begin
      if (!found) begin
        resp_next.status   = ST_MISS;
        resp_next.position = '0;
      end
    end else begin
      resp_next.status = ST_DONE;
    end
    resp_next.entry_count = POS_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      resp_valid <= 1'b0;
    end else if (fire) begin
      resp_valid <= 1'b1;
    end else if (resp_ready) begin
      resp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      resp <= resp_next;
    end
  end

endmodule
